[rtl/core/hsc_pkg.sv]
// Package with the item types, status codes and position helpers of the Hamming codec.
`timescale 1ns / 1ps

package hsc_pkg;

	localparam int MaxCodeBits = 63;
	localparam int WordBits    = 63;
	localparam int CountBits   = 6;
	localparam int CheckMax    = 6;
	localparam int DataMax     = MaxCodeBits - CheckMax;

	typedef enum logic {
		ACT_ENCODE = 1'b0,
		ACT_DECODE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAN     = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_BEYOND    = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	typedef struct packed {
		action_t                action;
		logic [CountBits-1:0]   bit_count;
		logic [WordBits-1:0]    word;
	} cmd_t;

	typedef struct packed {
		logic [WordBits-1:0]    result_word;
		logic [CountBits-1:0]   result_count;
		logic [CountBits-1:0]   syndrome;
		status_t                status;
	} res_t;

	// Position (from 1) of the j-th data bit: the j-th position that is not a power of two.
	function automatic int data_pos(input int j);
		int cnt;
		int r;
		cnt = 0;
		r = 0;
		for (int p = 1; p <= MaxCodeBits; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == j) begin
					r = p;
				end
				cnt++;
			end
		end
		return r;
	endfunction

	// Word mask of all positions whose index has bit j set.
	function automatic logic [WordBits-1:0] pos_mask(input int j);
		logic [WordBits-1:0] m;
		m = '0;
		for (int p = 1; p <= WordBits; p++) begin
			m[p-1] = ((p >> j) & 1) != 0;
		end
		return m;
	endfunction

	// Smallest k with 2^k >= n + k + 1.
	function automatic logic [2:0] check_bits(input logic [CountBits-1:0] n);
		logic [2:0] k;
		k = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if ((8'd1 << i) >= 8'({2'b00, n}) + 8'(i) + 8'd1) begin
				k = 3'(i);
			end
		end
		return k;
	endfunction

	// Number of power-of-two positions within 1..n.
	function automatic logic [2:0] pow2_count(input logic [CountBits-1:0] n);
		logic [2:0] c;
		c = '0;
		for (int i = 0; i < CountBits; i++) begin
			if ((7'd1 << i) <= {1'b0, n}) begin
				c = c + 3'd1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/hamming_sec_codec_core.sv]
// Top level of the Hamming single-error-correcting encoder and decoder.
`timescale 1ns / 1ps

// The codec takes one item per clock unless cmd_stall is raised by a stalled, full pipeline.
// An accepted item is captured in an input register, coded by fixed XOR trees and bit masks,
// and the result lands in an output register, from which it is offered on the output. The
// block keeps no state between items. A result that waits on a stalled output holds the
// output register while one more item can still enter the input register.
module hamming_sec_codec_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  hsc_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output hsc_pkg::res_t  res
);
	import hsc_pkg::*;

	logic                 v_s1;
	cmd_t                 cmd_s1;
	logic                 v_s2;
	res_t                 res_s2;
	logic                 s1_load;
	logic                 s2_load;

	logic [WordBits-1:0]  wm;
	logic [2:0]           k;
	logic [6:0]           total;
	logic                 too_long;
	logic [WordBits-1:0]  enc_data;
	logic [WordBits-1:0]  enc_word;
	logic [CountBits-1:0] syn;
	logic                 flip;
	logic [WordBits-1:0]  cw;
	logic [WordBits-1:0]  dec_data;
	res_t                 res_d;

	assign s2_load   = v_s1 && (!v_s2 || !res_stall);
	assign s1_load   = !v_s1 || s2_load;
	assign cmd_stall = !s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				v_s1 <= cmd_valid;
			end
			if (s2_load) begin
				v_s2 <= 1'b1;
			end else if (!res_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (s2_load) begin
			res_s2 <= res_d;
		end
	end

	// Bits at or above the count are ignored.
	assign wm = cmd_s1.word & ~({WordBits{1'b1}} << cmd_s1.bit_count);

	assign k        = check_bits(cmd_s1.bit_count);
	assign total    = 7'(cmd_s1.bit_count) + 7'(k);
	assign too_long = total > 7'(MaxCodeBits);

	always_comb begin
		enc_data = '0;
		for (int j = 0; j < DataMax; j++) begin
			enc_data[data_pos(j)-1] = wm[j];
		end
		enc_word = enc_data;
		for (int j = 0; j < CheckMax; j++) begin
			enc_word[(1 << j) - 1] = ^(enc_data & pos_mask(j));
		end
	end

	always_comb begin
		for (int j = 0; j < CountBits; j++) begin
			syn[j] = ^(wm & pos_mask(j));
		end
	end

	assign flip = (syn != '0) && (syn <= cmd_s1.bit_count);
	assign cw   = flip ? (wm ^ (WordBits'(1) << (syn - CountBits'(1)))) : wm;

	always_comb begin
		dec_data = '0;
		for (int j = 0; j < DataMax; j++) begin
			dec_data[j] = cw[data_pos(j)-1];
		end
	end

	always_comb begin
		res_d = '0;
		if (cmd_s1.action == ACT_ENCODE) begin
			if (too_long) begin
				res_d.status = ST_TOO_LONG;
			end else begin
				res_d.result_word  = enc_word;
				res_d.result_count = total[CountBits-1:0];
				res_d.status       = ST_CLEAN;
			end
		end else begin
			res_d.result_word  = dec_data;
			res_d.result_count = cmd_s1.bit_count - CountBits'(pow2_count(cmd_s1.bit_count));
			res_d.syndrome     = syn;
			if (syn == '0) begin
				res_d.status = ST_CLEAN;
			end else if (flip) begin
				res_d.status = ST_CORRECTED;
			end else begin
				res_d.status = ST_BEYOND;
			end
		end
	end

	assign res_valid = v_s2;
	assign res       = res_s2;

	a_too_long_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_TOO_LONG) |->
		(res.result_word == '0 && res.result_count == '0 && res.syndrome == '0))
		else $error("length overflow result carries data");

	a_clean_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_CLEAN) |-> (res.syndrome == '0))
		else $error("clean result with nonzero syndrome");

	a_corrected_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == ST_CORRECTED || res.status == ST_BEYOND)) |->
		(res.syndrome != '0))
		else $error("correction reported with zero syndrome");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (v_s1 && v_s2 && res_stall))
		else $error("input stalled while pipeline has room");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> v_s1)
		else $error("accepted item lost from input register");

endmodule
